>>> rtl/core/qts_pkg.sv
// Shared constants for the two-stack queue: widths, status and command codes,
// register indexes and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qts_pkg;

  // Parameter defaults
  localparam int STACK_DEPTH_DEF = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int CAP_W     = 9;
  localparam int DROP_W    = 9;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes and reset value
  localparam logic [CFG_IDX_W-1:0] REG_IN_CAP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAP = 1'd1;
  localparam logic [CAP_W-1:0]     CAP_RESET   = 9'd256;

  // Commands
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

>>> rtl/core/qts_ifs.sv
// Valid/ready channel interfaces for command transactions and result transactions.
// Depends on qts_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface qts_in_if #(
  parameter int VALUE_WIDTH = qts_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [VALUE_WIDTH-1:0] in_value;

  modport source (output valid, output cmd, output in_value, input ready);
  modport sink   (input valid, input cmd, input in_value, output ready);
endinterface

interface qts_out_if #(
  parameter int VALUE_WIDTH = qts_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [qts_pkg::STATUS_W-1:0]  status;
  logic signed [VALUE_WIDTH-1:0] out_value;
  logic [qts_pkg::DROP_W-1:0]    dropped_count;

  modport source (output valid, output status, output out_value, output dropped_count,
                  input ready);
  modport sink   (input valid, input status, input out_value, input dropped_count,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/queue_from_two_stacks_unit.sv
// Top level of the two-stack queue: sequencer plus in-stack and out-stack memories.
// Depends on qts_pkg, qts_ifs, qts_stack_ram and qts_ctrl.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    cmd, in_value
//   out_ch    out  valid/ready    status, out_value, dropped_count
//   cfg       in   cfg_we         cfg_index, cfg_data (write only)
//
// Enqueue passes S_DONE; dequeue from a non-empty out-stack passes S_WAIT, then S_DONE.
// A dequeue that finds the out-stack empty moves the in-stack one entry per cycle
// through the single read port of the in-stack memory, then passes S_POP, S_WAIT, S_DONE.
// in_ch.ready is high only while the sequencer is idle; one result register holds
// a result while out_ch stalls, and the next command is taken meanwhile.
// Reset (synchronous, rst high) clears the counters and the sequencer; stack
// contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module queue_from_two_stacks_unit #(
  parameter int STACK_DEPTH = qts_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = qts_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  qts_in_if.sink                             in_ch,
  qts_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [qts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [qts_pkg::CAP_W-1:0]     cfg_data
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic                   in_we;
  logic [AW-1:0]          in_waddr;
  logic [VALUE_WIDTH-1:0] in_wdata;
  logic                   in_re;
  logic [AW-1:0]          in_raddr;
  logic [VALUE_WIDTH-1:0] in_rdata;
  logic                   out_we;
  logic [AW-1:0]          out_waddr;
  logic [VALUE_WIDTH-1:0] out_wdata;
  logic                   out_re;
  logic [AW-1:0]          out_raddr;
  logic [VALUE_WIDTH-1:0] out_rdata;

  // Sequencer
  qts_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_we     (in_we),
    .in_waddr  (in_waddr),
    .in_wdata  (in_wdata),
    .in_re     (in_re),
    .in_raddr  (in_raddr),
    .in_rdata  (in_rdata),
    .out_we    (out_we),
    .out_waddr (out_waddr),
    .out_wdata (out_wdata),
    .out_re    (out_re),
    .out_raddr (out_raddr),
    .out_rdata (out_rdata)
  );

  // In-stack storage
  qts_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (in_wdata),
    .re    (in_re),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  // Out-stack storage
  qts_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (out_wdata),
    .re    (out_re),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

endmodule

`default_nettype wire

>>> rtl/core/qts_stack_ram.sv
// Stack storage: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module qts_stack_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/qts_ctrl.sv
// Sequencer for the two-stack queue: counters, capacity checks, element-by-element
// transfer between the stacks and the result register.
// Depends on qts_pkg and qts_ifs.
`timescale 1ns / 1ps
`default_nettype none

module qts_ctrl #(
  parameter int STACK_DEPTH = qts_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = qts_pkg::VALUE_WIDTH_DEF,
  localparam int AW         = $clog2(STACK_DEPTH),
  localparam int CW         = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  qts_in_if.sink                             in_ch,
  qts_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [qts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [qts_pkg::CAP_W-1:0]     cfg_data,
  // in-stack memory
  output logic                               in_we,
  output logic [AW-1:0]                      in_waddr,
  output logic [VALUE_WIDTH-1:0]             in_wdata,
  output logic                               in_re,
  output logic [AW-1:0]                      in_raddr,
  input  wire logic [VALUE_WIDTH-1:0]        in_rdata,
  // out-stack memory
  output logic                               out_we,
  output logic [AW-1:0]                      out_waddr,
  output logic [VALUE_WIDTH-1:0]             out_wdata,
  output logic                               out_re,
  output logic [AW-1:0]                      out_raddr,
  input  wire logic [VALUE_WIDTH-1:0]        out_rdata
);

  localparam int CAPW = (CW > qts_pkg::CAP_W) ? CW : qts_pkg::CAP_W;
  localparam logic [CAPW-1:0] DEPTH_C = CAPW'(STACK_DEPTH);
  localparam logic [CAPW-1:0] ONE_C   = CAPW'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_XFER = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                    state;
  logic [CW-1:0]                 in_count;
  logic [CW-1:0]                 out_count;
  logic [qts_pkg::CAP_W-1:0]     in_cap;
  logic [qts_pkg::CAP_W-1:0]     out_cap;
  logic [qts_pkg::STATUS_W-1:0]  res_status;
  logic [VALUE_WIDTH-1:0]        res_value;
  logic [CW-1:0]                 res_dropped;
  logic                          pend_valid;
  logic [AW-1:0]                 pend_addr;

  logic                          accept;
  logic                          is_enq;
  logic [CW-1:0]                 in_top;
  logic [CW-1:0]                 out_top;
  logic [CAPW-1:0]               in_cap_eff;
  logic [CAPW-1:0]               out_cap_eff;
  logic                          in_full;
  logic                          out_room;
  logic                          res_load;

  assign accept   = in_ch.valid && in_ch.ready;
  assign is_enq   = (in_ch.cmd == qts_pkg::CMD_ENQ);
  assign in_top   = in_count - CW'(1);
  assign out_top  = out_count - CW'(1);
  assign res_load = (state == S_DONE) && (!out_ch.valid || out_ch.ready);

  // Clamp capacities to one..depth
  always_comb begin
    if (in_cap == '0) begin
      in_cap_eff = ONE_C;
    end else if (CAPW'(in_cap) > DEPTH_C) begin
      in_cap_eff = DEPTH_C;
    end else begin
      in_cap_eff = CAPW'(in_cap);
    end
    if (out_cap == '0) begin
      out_cap_eff = ONE_C;
    end else if (CAPW'(out_cap) > DEPTH_C) begin
      out_cap_eff = DEPTH_C;
    end else begin
      out_cap_eff = CAPW'(out_cap);
    end
  end

  assign in_full  = CAPW'(in_count) >= in_cap_eff;
  assign out_room = CAPW'(out_count) < out_cap_eff;

  assign in_ch.ready = (state == S_IDLE);

  // Memory port control
  always_comb begin
    in_we     = accept && is_enq && !in_full;
    in_waddr  = in_count[AW-1:0];
    in_wdata  = in_ch.in_value;
    in_re     = (state == S_XFER) && (in_count != '0);
    in_raddr  = in_top[AW-1:0];
    out_we    = pend_valid;
    out_waddr = pend_addr;
    out_wdata = in_rdata;
    out_re    = (state == S_POP) ||
                (accept && !is_enq && (out_count != '0));
    out_raddr = out_top[AW-1:0];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_cap  <= qts_pkg::CAP_RESET;
      out_cap <= qts_pkg::CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qts_pkg::REG_IN_CAP:  in_cap  <= cfg_data;
        qts_pkg::REG_OUT_CAP: out_cap <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_count   <= '0;
      out_count  <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_dropped <= '0;
            res_value   <= '0;
            if (is_enq) begin
              res_status <= in_full ? qts_pkg::ST_FULL : qts_pkg::ST_OK;
              if (!in_full) begin
                in_count <= in_count + CW'(1);
              end
              state <= S_DONE;
            end else if (out_count != '0) begin
              out_count <= out_top;
              state     <= S_WAIT;
            end else if (in_count != '0) begin
              state <= S_XFER;
            end else begin
              res_status <= qts_pkg::ST_EMPTY;
              state      <= S_DONE;
            end
          end
        end
        S_XFER: begin
          // Move one entry per cycle, newest first; drop once the out-stack is full
          if (in_count != '0) begin
            in_count <= in_top;
            if (out_room) begin
              pend_valid <= 1'b1;
              pend_addr  <= out_count[AW-1:0];
              out_count  <= out_count + CW'(1);
            end else begin
              res_dropped <= res_dropped + CW'(1);
            end
          end else begin
            state <= S_POP;
          end
        end
        S_POP: begin
          out_count <= out_top;
          state     <= S_WAIT;
        end
        S_WAIT: begin
          res_status <= qts_pkg::ST_OK;
          res_value  <= out_rdata;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (res_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_ch.status        <= res_status;
      out_ch.out_value     <= res_value;
      out_ch.dropped_count <= qts_pkg::DROP_W'(res_dropped);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/qts_checker.sv
// Port-level checks for the two-stack queue, bound to the top level.
// Depends on qts_pkg and queue_from_two_stacks_unit.
`timescale 1ns / 1ps
`default_nettype none

module qts_checker #(
  parameter int VALUE_WIDTH = qts_pkg::VALUE_WIDTH_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [qts_pkg::STATUS_W-1:0] status,
  input wire logic [VALUE_WIDTH-1:0]       out_value,
  input wire logic [qts_pkg::DROP_W-1:0]   dropped_count
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_value)
      && $stable(dropped_count))
    else $error("result changed while stalled");

  // The block works on one command at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a command transaction");

  // Only a successful dequeue carries a value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != qts_pkg::ST_OK) |-> out_value == '0)
    else $error("nonzero value on a failed command");

  // Drops happen only in a transfer that ends in a successful pop
  a_drop_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (dropped_count != '0) |-> status == qts_pkg::ST_OK)
    else $error("drop count on a failed command");

  // No result right out of reset
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind queue_from_two_stacks_unit qts_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_qts_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .out_value     (out_ch.out_value),
  .dropped_count (out_ch.dropped_count)
);

`default_nettype wire

>>> tb/qts_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the two-stack queue: mirrors the queue from the command
// and register-write traffic and compares every result transaction in order.
// Depends on qts_pkg and the channel interfaces in qts_ifs.

module qts_result_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  qts_in_if                                  in_mon,
  qts_out_if                                 out_mon,
  input  wire logic                          cfg_we,
  input  wire logic [qts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [qts_pkg::CAP_W-1:0]     cfg_data,
  output int                                 fail_count,
  output int                                 pending
);
  import qts_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [31:0]         value;
    logic [DROP_W-1:0]   dropped;
  } queue_result_t;

  // Mirrored queue state
  logic [31:0]      in_words  [STACK_DEPTH_DEF];
  logic [31:0]      out_words [STACK_DEPTH_DEF];
  int               in_fill;
  int               out_fill;
  logic [CAP_W-1:0] in_cap_reg;
  logic [CAP_W-1:0] out_cap_reg;
  queue_result_t    expected_results [$];

  initial fail_count = 0;

  // Map a capacity register onto the depth actually usable
  function automatic int usable_depth(input logic [CAP_W-1:0] cap_reg);
    if (cap_reg == '0) return 1;
    if (cap_reg > STACK_DEPTH_DEF) return STACK_DEPTH_DEF;
    return int'(cap_reg);
  endfunction

  // Apply one command to the mirror and return the result it must produce
  function automatic queue_result_t predict_outcome(input logic cmd, input logic [31:0] val);
    queue_result_t res;
    int            cap;
    res = '0;
    res.status = ST_OK;
    if (cmd == CMD_ENQ) begin
      if (in_fill >= usable_depth(in_cap_reg)) begin
        res.status = ST_FULL;
      end else begin
        in_words[in_fill] = val;
        in_fill++;
      end
    end else if (in_fill == 0 && out_fill == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // Refill the out-stack newest first; whatever does not fit is lost
      if (out_fill == 0) begin
        cap = usable_depth(out_cap_reg);
        while (in_fill > 0) begin
          in_fill--;
          if (out_fill < cap) begin
            out_words[out_fill] = in_words[in_fill];
            out_fill++;
          end else begin
            res.dropped = res.dropped + 1'b1;
          end
        end
      end
      out_fill--;
      res.value = out_words[out_fill];
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
    fail_count++;
  endtask

  // Compare results, track register writes, predict on accepted commands
  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t seen;
    if (rst) begin
      in_fill     = 0;
      out_fill    = 0;
      in_cap_reg  = CAP_RESET;
      out_cap_reg = CAP_RESET;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen.status  = out_mon.status;
        seen.value   = out_mon.out_value;
        seen.dropped = out_mon.dropped_count;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no command pending: expected none, actual %0d/%0d/%0d",
                   $time, seen.status, $signed(seen.value), seen.dropped);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (seen.status !== want.status)
            flag_mismatch("status", {30'd0, want.status}, {30'd0, seen.status});
          if (seen.value !== want.value)
            flag_mismatch("out_value", want.value, seen.value);
          if (seen.dropped !== want.dropped)
            flag_mismatch("dropped_count", {23'd0, want.dropped}, {23'd0, seen.dropped});
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_IN_CAP) in_cap_reg = cfg_data;
        else if (cfg_index == REG_OUT_CAP) out_cap_reg = cfg_data;
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_outcome(in_mon.cmd, in_mon.in_value));
    end
    pending <= expected_results.size();
  end

endmodule

>>> tb/tb_queue_from_two_stacks_unit.sv
`timescale 1ns / 1ps
// Testbench top for the two-stack queue: clock, reset, command and register
// stimulus, result-side backpressure and the final verdict.
// Depends on qts_pkg, qts_ifs, the queue RTL and qts_result_checker.

module tb_queue_from_two_stacks_unit;
  import qts_pkg::*;

  localparam int TOTAL_ITEMS      = 1830;
  localparam int QUIET_FROM       = 1500;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 300;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CAP_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;
  bit                   quiet = 1'b0;
  int                   hold_requests = 0;
  int                   sent_items = 0;

  qts_in_if  in_ch ();
  qts_out_if out_ch ();

  queue_from_two_stacks_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qts_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random stalls, one long hold on request, none when quiet
  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests > holds_done) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 10)) @(posedge clk);
      end
    end
  end

  // Offer one command transaction and hold it until accepted
  task automatic offer(input logic cmd, input logic [31:0] val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.in_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  // Drop valid and wait until every result has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_caps(input logic [CAP_W-1:0] in_cap, input logic [CAP_W-1:0] out_cap);
    write_reg(REG_IN_CAP, in_cap);
    write_reg(REG_OUT_CAP, out_cap);
  endtask

  initial begin : stimulus
    int               phase;
    int               span;
    int               burst;
    int               in_eff;
    bit               enq_mode;
    bit               fill_burst;
    bit               do_enq;
    logic [CAP_W-1:0] cap_in;
    logic [CAP_W-1:0] cap_out;
    logic [31:0]      val;

    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_ENQ;
    in_ch.in_value <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_IN_CAP;
    cfg_data       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty dequeue, extreme values through the queue in order, empty again
    offer(CMD_DEQ, 32'h1234_5678);
    offer(CMD_ENQ, 32'h8000_0000);
    offer(CMD_ENQ, 32'h7FFF_FFFF);
    offer(CMD_ENQ, 32'h0000_0000);
    offer(CMD_ENQ, 32'hFFFF_FFFF);
    repeat (5) offer(CMD_DEQ, 32'hFFFF_FFFF);
    settle();

    // Zero out capacity acts as one: full in-stack despite room, then overflow on move
    set_caps(9'd2, 9'd0);
    offer(CMD_ENQ, 32'hA5A5_A5A5);
    offer(CMD_ENQ, 32'h5A5A_5A5A);
    offer(CMD_ENQ, 32'h0000_0001);
    offer(CMD_DEQ, 32'h0);
    offer(CMD_DEQ, 32'h0);
    settle();

    // Oversized in capacity clamps; move drops the oldest two
    set_caps(9'd511, 9'd2);
    for (int i = 0; i < 4; i++) offer(CMD_ENQ, 32'h100 + i);
    offer(CMD_DEQ, 32'h0);
    offer(CMD_ENQ, 32'h200);
    offer(CMD_ENQ, 32'h201);
    settle();

    // In capacity lowered below the fill level: held entries still come out
    set_caps(9'd1, 9'd3);
    offer(CMD_ENQ, 32'h300);
    repeat (4) offer(CMD_DEQ, 32'h0);
    settle();

    // Random phases: each starts with a clean fill burst, then alternating bursts with noise
    phase    = 0;
    enq_mode = 1'b0;
    while (sent_items < TOTAL_ITEMS) begin
      case (phase)
        0: begin cap_in = CAP_RESET; cap_out = CAP_RESET; end
        1: begin cap_in = 9'd0;      cap_out = 9'd0;      end
        2: begin cap_in = 9'd511;    cap_out = 9'd0;      end
        3: begin cap_in = 9'd1;      cap_out = 9'd511;    end
        4: begin cap_in = 9'd300;    cap_out = 9'd257;    end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            cap_in  = CAP_W'($urandom_range(0, 511));
            cap_out = CAP_W'($urandom_range(0, 511));
          end else begin
            cap_in  = CAP_W'($urandom_range(0, 16));
            cap_out = CAP_W'($urandom_range(0, 16));
          end
        end
      endcase
      set_caps(cap_in, cap_out);
      in_eff     = (cap_in == '0) ? 1 : (cap_in > STACK_DEPTH_DEF) ? STACK_DEPTH_DEF : cap_in;
      span       = (in_eff > 32) ? 360 : 90;
      quiet      = (sent_items >= QUIET_FROM);
      enq_mode   = 1'b1;
      fill_burst = 1'b1;
      burst      = in_eff + 3;
      // Stall the result side for a long stretch while commands keep coming
      if (phase == 5) hold_requests++;
      repeat (span) begin
        if (burst == 0) begin
          enq_mode   = !enq_mode;
          fill_burst = 1'b0;
          burst      = $urandom_range(1, in_eff + 3);
        end
        burst--;
        do_enq = (fill_burst || $urandom_range(0, 99) >= 10) ? enq_mode : !enq_mode;
        case ($urandom_range(0, 9))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'hFFFF_FFFF;
          3:       val = 32'h0000_0000;
          default: val = $urandom();
        endcase
        offer(do_enq ? CMD_ENQ : CMD_DEQ, val);
      end
      settle();
      phase++;
    end

    // Catch any stray result after the last one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/qts_pkg.sv
rtl/core/qts_ifs.sv
rtl/core/qts_stack_ram.sv
rtl/core/qts_ctrl.sv
rtl/core/queue_from_two_stacks_unit.sv
rtl/core/qts_checker.sv
tb/qts_result_checker.sv
tb/tb_queue_from_two_stacks_unit.sv
